[rtl/ecdf_pkg.sv]
package ecdf_pkg;

   // Fixed field widths
   localparam int CDF_FRAC_BITS = 16;
   localparam int DRAW_W        = CDF_FRAC_BITS;
   localparam int CDF_W         = CDF_FRAC_BITS + 1;
   localparam int VAL_W         = 32;
   localparam int ENTRY_W       = CDF_W + VAL_W;
   localparam int PROD_W        = CDF_W + VAL_W;
   localparam int INDEX_W       = 10;
   localparam int COUNT_W       = 11;
   localparam int MODE_W        = 2;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   // Register file port
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   // Register indexes, taken from paddr[2]
   localparam logic REG_INTERP_MODE = 1'b0;
   localparam logic REG_ENTRY_COUNT = 1'b1;

   // Interpolation modes
   localparam logic [MODE_W-1:0] MODE_DISCRETE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CEIL     = 2'd2;

   // Transaction kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] num;
      logic [CDF_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quot;
      logic              rem_nz;
   } div_rsp_type;

endpackage

[rtl/ecdf_table.sv]
module ecdf_table
   import ecdf_pkg::*;
#(
   parameter int DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ecdf_div.sv]
module ecdf_div
   import ecdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [CDF_W-1:0]  rem_ff,  rem_in;
   logic [PROD_W-1:0] quo_ff,  quo_in;
   logic [CDF_W-1:0]  den_ff,  den_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              run_ff,  run_in;
   logic              done_ff, done_in;

   logic [CDF_W:0] trial;
   logic [CDF_W:0] diff;

   // One restoring step: shift in the next dividend bit, try to subtract
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.num;
         den_in = req.den;
         cnt_in = CNT_W'(PROD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[CDF_W]) begin
            rem_in = diff[CDF_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CDF_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.quot   = quo_ff;
   assign rsp.rem_nz = |rem_ff;

endmodule

[rtl/ecdf_csr.sv]
module ecdf_csr
   import ecdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [MODE_W-1:0]  mode_ff,  mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel & penable & pwrite;

   // Decode the write transaction
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (wr_hit) begin
         if (paddr[2] == REG_INTERP_MODE) begin
            mode_in = pwdata[MODE_W-1:0];
         end else begin
            count_in = pwdata[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   // Read back
   assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? APB_DATA_W'(count_ff)
                                                 : APB_DATA_W'(mode_ff);

   assign cfg.mode  = mode_ff;
   assign cfg.count = count_ff;

endmodule

[rtl/empirical_cdf_sampler.sv]
// Write transaction: taken while idle, busy stays low, no result.
// Sample transaction: result from the idle state for an empty table, from the first step
// when the draw is at or below entry 0, else after a binary search of at most ceil(log2(n-1))
// steps over the single table read port; interpolation adds the one-bit-per-cycle divider.
// busy drops as the result appears, so one sample at a time; the receiver cannot stall.
// Synchronous active-high reset clears the sequencer, strobe and config registers; not the table.
module empirical_cdf_sampler
   import ecdf_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_kind,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [CDF_W-1:0]      req_entry_cdf,
   input  logic [VAL_W-1:0]      req_entry_value,
   input  logic [DRAW_W-1:0]     req_draw,
   output logic                  rsp_strobe,
   output logic [VAL_W-1:0]      rsp_sample_value,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int NW    = AW + 1;
   localparam int IXC_W = (NW > INDEX_W) ? NW : INDEX_W;
   localparam int CNC_W = (NW > COUNT_W) ? NW : COUNT_W;
   localparam int QA_W  = PROD_W + 1;
   localparam int RES_W = QA_W + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_FIRST, S_SEARCH, S_PROBE, S_HI, S_LO, S_MUL, S_DIV, S_ROUND
   } state_type;

   cfg_type            cfg;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               accept;
   logic               wr_en;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [CDF_W-1:0]   rd_cdf;
   logic [VAL_W-1:0]   rd_val;

   state_type          state_ff, state_in;
   logic [DRAW_W-1:0]  x_ff,     x_in;
   logic [NW-1:0]      n_ff,     n_in;
   logic [AW-1:0]      lo_ff,    lo_in;
   logic [AW-1:0]      hi_ff,    hi_in;
   logic [AW-1:0]      mid_ff,   mid_in;
   logic [AW-1:0]      idx_ff,   idx_in;
   logic [CDF_W-1:0]   x2_ff,    x2_in;
   logic [VAL_W-1:0]   y2_ff,    y2_in;
   logic [VAL_W-1:0]   y1_ff,    y1_in;
   logic [CDF_W-1:0]   dx_ff,    dx_in;
   logic [VAL_W-1:0]   dy_ff,    dy_in;
   logic [CDF_W-1:0]   dd_ff,    dd_in;
   logic               neg_ff,   neg_in;
   logic [QA_W-1:0]    qa_ff,    qa_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [VAL_W-1:0]   rsp_value_ff,  rsp_value_in;

   logic [CNC_W-1:0]   cnt_ext;
   logic [NW-1:0]      nm1;
   logic [NW-1:0]      mid_sum;
   logic [CDF_W-1:0]   x_ext;
   logic [CDF_W:0]     dxs;
   logic [VAL_W:0]     dys;
   logic [CDF_W:0]     dds;
   logic [PROD_W-1:0]  prod;
   logic               up;
   logic [RES_W-1:0]   res;

   assign accept = start & ~busy;
   assign busy   = (state_ff != S_IDLE);
   assign wr_en  = accept && (req_kind == KIND_WRITE)
                   && (IXC_W'(req_entry_index) < IXC_W'(TABLE_DEPTH));

   ecdf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ecdf_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({req_entry_cdf, req_entry_value}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ecdf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rd_cdf  = rd_data[ENTRY_W-1:VAL_W];
   assign rd_val  = rd_data[VAL_W-1:0];
   assign x_ext   = CDF_W'(x_ff);
   assign cnt_ext = CNC_W'(cfg.count);
   assign nm1     = n_ff - 1'b1;
   assign mid_sum = NW'(lo_ff) + NW'(hi_ff);
   assign up      = (cfg.mode == MODE_CEIL);

   // Signed differences against the lower neighbor
   assign dxs  = {1'b0, x_ext} - {1'b0, rd_cdf};
   assign dys  = {1'b0, y2_ff} - {1'b0, rd_val};
   assign dds  = {1'b0, x2_ff} - {1'b0, rd_cdf};
   assign prod = dx_ff * dy_ff;

   // Apply the rounded quotient to the lower value
   assign res = neg_ff ? (RES_W'(y1_ff) - RES_W'(qa_ff))
                       : (RES_W'(y1_ff) + RES_W'(qa_ff));

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      n_in          = n_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      x2_in         = x2_ff;
      y2_in         = y2_ff;
      y1_in         = y1_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dd_in         = dd_ff;
      neg_in        = neg_ff;
      qa_in         = qa_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rd_addr       = '0;
      div_req.start = 1'b0;
      div_req.num   = prod;
      div_req.den   = dd_ff;
      case (state_ff)
         S_IDLE: begin
            // Entry 0 is read while idle so it is ready in the first step
            if (accept && (req_kind == KIND_SAMPLE)) begin
               x_in = req_draw;
               if (cnt_ext > CNC_W'(TABLE_DEPTH)) begin
                  n_in = NW'(TABLE_DEPTH);
               end else begin
                  n_in = NW'(cnt_ext);
               end
               if (cfg.count == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_value_in  = '0;
               end else begin
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            // Draw at or below the first point returns entry 0
            if (x_ext <= rd_cdf) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = rd_val;
               state_in      = S_IDLE;
            end else begin
               lo_in    = AW'(1);
               hi_in    = nm1[AW-1:0];
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[NW-1:1];
               rd_addr  = mid_sum[NW-1:1];
               state_in = S_PROBE;
            end else begin
               // Clamp an overrun to the last entry
               if (NW'(lo_ff) > nm1) begin
                  idx_in  = nm1[AW-1:0];
                  rd_addr = nm1[AW-1:0];
               end else begin
                  idx_in  = lo_ff;
                  rd_addr = lo_ff;
               end
               state_in = S_HI;
            end
         end
         S_PROBE: begin
            if (x_ext > rd_cdf) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end
         S_HI: begin
            x2_in = rd_cdf;
            y2_in = rd_val;
            if ((idx_ff == '0) || (cfg.mode == MODE_DISCRETE) || !(x_ext < rd_cdf)) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = rd_val;
               state_in      = S_IDLE;
            end else begin
               rd_addr  = idx_ff - 1'b1;
               state_in = S_LO;
            end
         end
         S_LO: begin
            // Split into magnitudes and one combined sign
            y1_in  = rd_val;
            dx_in  = dxs[CDF_W] ? CDF_W'(-dxs) : dxs[CDF_W-1:0];
            dy_in  = dys[VAL_W] ? VAL_W'(-dys) : dys[VAL_W-1:0];
            dd_in  = dds[CDF_W] ? CDF_W'(-dds) : dds[CDF_W-1:0];
            neg_in = dxs[CDF_W] ^ dys[VAL_W] ^ dds[CDF_W];
            if (dds == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = y2_ff;
               state_in      = S_IDLE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            div_req.start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            // Round the magnitude away from zero where floor or ceiling asks it
            if (div_rsp.done) begin
               qa_in = QA_W'(div_rsp.quot)
                       + QA_W'(div_rsp.rem_nz && (neg_ff ? !up : up));
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            // Clamp to the unsigned value range
            rsp_strobe_in = 1'b1;
            if (res[RES_W-1]) begin
               rsp_value_in = '0;
            end else if (|res[RES_W-2:VAL_W]) begin
               rsp_value_in = '1;
            end else begin
               rsp_value_in = res[VAL_W-1:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      x_ff         <= x_in;
      n_ff         <= n_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      idx_ff       <= idx_in;
      x2_ff        <= x2_in;
      y2_ff        <= y2_in;
      y1_ff        <= y1_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dd_ff        <= dd_in;
      neg_ff       <= neg_in;
      qa_ff        <= qa_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_sample_value = rsp_value_ff;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
   import ecdf_pkg::*;

   localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int CDF_ONE     = 1 << CDF_FRAC_BITS;
   localparam int ITEM_BUDGET = 1900;
   localparam int REPORT_MAX  = 10;

   // Modes with no constant of their own in the package
   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

   typedef struct {
      logic               kind;
      logic [INDEX_W-1:0] entry_index;
      logic [CDF_W-1:0]   entry_cdf;
      logic [VAL_W-1:0]   entry_value;
      logic [DRAW_W-1:0]  draw;
   } sampler_op_type;

   logic                  clock;
   logic                  reset;
   logic                  start           = 1'b0;
   logic                  busy;
   logic                  req_kind        = 1'b0;
   logic [INDEX_W-1:0]    req_entry_index = '0;
   logic [CDF_W-1:0]      req_entry_cdf   = '0;
   logic [VAL_W-1:0]      req_entry_value = '0;
   logic [DRAW_W-1:0]     req_draw        = '0;
   logic                  rsp_strobe;
   logic [VAL_W-1:0]      rsp_sample_value;
   logic                  psel            = 1'b0;
   logic                  penable         = 1'b0;
   logic                  pwrite          = 1'b0;
   logic [APB_ADDR_W-1:0] paddr           = '0;
   logic [APB_DATA_W-1:0] pwdata          = '0;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   // Shadow of the table and the registers, updated as transactions are accepted
   bit   [CDF_W-1:0]  cdf_points   [TABLE_DEPTH];
   bit   [VAL_W-1:0]  point_values [TABLE_DEPTH];
   logic [MODE_W-1:0] cur_mode  = MODE_DISCRETE;
   logic [COUNT_W-1:0] cur_count = '0;

   // CDF points as queued, used only to aim draws at the table
   int planned_cdf [TABLE_DEPTH];

   sampler_op_type   pending_ops[$];
   logic [VAL_W-1:0] expected_samples[$];
   sampler_op_type   live_op;
   int               items_in_flight = 0;
   int               items_queued    = 0;
   int               gap_left        = 0;
   int               gap_ceiling     = 0;
   int               writes_sent     = 0;
   int               samples_sent    = 0;
   int               samples_seen    = 0;
   int               settings_used   = 0;
   int               fault_count     = 0;

   empirical_cdf_sampler i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_entry_index  (req_entry_index),
      .req_entry_cdf    (req_entry_cdf),
      .req_entry_value  (req_entry_value),
      .req_draw         (req_draw),
      .rsp_strobe       (rsp_strobe),
      .rsp_sample_value (rsp_sample_value),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Inverse CDF lookup: first entry at or above the draw, then optional interpolation
   function automatic logic [VAL_W-1:0] lookup_sample(input logic [DRAW_W-1:0] draw);
      int unsigned n_used, lo, hi, mid, pick;
      longint      x, x1, x2, y1, y2, span, prod, quo, res;
      n_used = (cur_count > COUNT_W'(TABLE_DEPTH)) ? TABLE_DEPTH : 32'(cur_count);
      if (n_used == 0) return '0;
      x = longint'(draw);
      if (x <= longint'(cdf_points[0])) begin
         pick = 0;
      end else begin
         lo = 1;
         hi = n_used - 1;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (x > longint'(cdf_points[mid])) lo = mid + 1;
            else hi = mid;
         end
         pick = lo;
      end
      if (pick > n_used - 1) pick = n_used - 1;
      if (pick == 0 || cur_mode == MODE_DISCRETE || x >= longint'(cdf_points[pick]))
         return point_values[pick];
      x1   = longint'(cdf_points[pick-1]);
      y1   = longint'(point_values[pick-1]);
      x2   = longint'(cdf_points[pick]);
      y2   = longint'(point_values[pick]);
      span = x2 - x1;
      if (span == 0) begin
         res = y2;
      end else begin
         prod = (x - x1) * (y2 - y1);
         quo  = prod / span;
         // Truncation goes toward zero: fix up to floor or ceiling
         if (prod % span != 0) begin
            if (cur_mode == MODE_CEIL && ((prod < 0) == (span < 0))) quo = quo + 1;
            else if (cur_mode != MODE_CEIL && ((prod < 0) != (span < 0))) quo = quo - 1;
         end
         res = y1 + quo;
      end
      if (res < 0) res = 0;
      if (res > longint'(32'hFFFF_FFFF)) res = longint'(32'hFFFF_FFFF);
      return res[VAL_W-1:0];
   endfunction

   // Driver: present queued transactions, with a random gap after each acceptance
   always @(posedge clock) begin
      logic drive_start;
      drive_start = start;
      if (reset) begin
         drive_start = 1'b0;
         gap_left    = 0;
      end else begin
         if (start && !busy) begin
            items_in_flight = items_in_flight - 1;
            if (live_op.kind == KIND_WRITE) begin
               cdf_points[live_op.entry_index]   = live_op.entry_cdf;
               point_values[live_op.entry_index] = live_op.entry_value;
               writes_sent = writes_sent + 1;
            end else begin
               expected_samples.push_back(lookup_sample(live_op.draw));
               samples_sent = samples_sent + 1;
            end
            drive_start = 1'b0;
         end
         if (!drive_start) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
            end else if (pending_ops.size() != 0) begin
               live_op         = pending_ops.pop_front();
               req_kind        <= live_op.kind;
               req_entry_index <= live_op.entry_index;
               req_entry_cdf   <= live_op.entry_cdf;
               req_entry_value <= live_op.entry_value;
               req_draw        <= live_op.draw;
               drive_start     = 1'b1;
               gap_left        = $urandom_range(gap_ceiling, 0);
            end
         end
      end
      start <= drive_start;
   end

   // Monitor: match each result strobe against the oldest pending sample
   always @(posedge clock) begin
      logic [VAL_W-1:0] want;
      if (!reset && rsp_strobe === 1'b1) begin
         samples_seen = samples_seen + 1;
         if (expected_samples.size() == 0) begin
            fault_count = fault_count + 1;
            if (fault_count <= REPORT_MAX)
               $display("tb: result %h with no sample pending", rsp_sample_value);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample_value !== want) begin
               fault_count = fault_count + 1;
               if (fault_count <= REPORT_MAX)
                  $display("tb: sample %0d mismatch: expected %h, got %h",
                           samples_seen, want, rsp_sample_value);
            end
         end
      end
   end

   function automatic void push_op(input sampler_op_type op);
      pending_ops.push_back(op);
      items_in_flight = items_in_flight + 1;
      items_queued    = items_queued + 1;
   endfunction

   function automatic void queue_write(input int idx, input int cdf, input logic [VAL_W-1:0] v);
      sampler_op_type op;
      op.kind        = KIND_WRITE;
      op.entry_index = INDEX_W'(idx);
      op.entry_cdf   = CDF_W'(cdf);
      op.entry_value = v;
      op.draw        = DRAW_W'($urandom());
      planned_cdf[idx] = cdf;
      push_op(op);
   endfunction

   function automatic void queue_sample(input logic [DRAW_W-1:0] draw);
      sampler_op_type op;
      op.kind        = KIND_SAMPLE;
      op.entry_index = INDEX_W'($urandom());
      op.entry_cdf   = CDF_W'($urandom_range(CDF_ONE));
      op.entry_value = $urandom();
      op.draw        = draw;
      push_op(op);
   endfunction

   // Draws: extremes, random, or aimed on and around a table point
   function automatic logic [DRAW_W-1:0] pick_draw(input int unsigned span_n);
      int unsigned roll;
      int          pt;
      roll = $urandom_range(15);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll < 8 || span_n == 0) return DRAW_W'($urandom());
      pt = planned_cdf[$urandom_range(span_n - 1)] + int'($urandom_range(2)) - 1;
      if (pt < 0) pt = 0;
      if (pt > CDF_ONE - 1) pt = CDF_ONE - 1;
      return DRAW_W'(pt);
   endfunction

   // Load entries 0..k-1, ascending with plateaus, or scattered
   function automatic void load_table(input int k, input bit ordered);
      int   spacing, c, prev;
      logic [VAL_W-1:0] v;
      prev    = 0;
      spacing = (k > 0) ? CDF_ONE / k : 0;
      for (int i = 0; i < k; i++) begin
         if (ordered) begin
            c = ((i + 1) * CDF_ONE) / k - int'($urandom_range(spacing / 2));
            if (i > 0 && $urandom_range(7) == 0) c = prev;
            if (i == k - 1 && $urandom_range(3) != 0) c = CDF_ONE;
         end else begin
            c = $urandom_range(CDF_ONE);
         end
         case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            default: v = $urandom();
         endcase
         queue_write(i, c, v);
         prev = c;
      end
   endfunction

   // Hold until nothing is queued, in flight or outstanding, then let the block drain
   task automatic settle_idle();
      while (items_in_flight != 0 || expected_samples.size() != 0 || busy === 1'b1)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic reg_sel, input logic [APB_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == REG_INTERP_MODE) cur_mode = data[MODE_W-1:0];
      else cur_count = data[COUNT_W-1:0];
   endtask

   task automatic set_config(input logic [MODE_W-1:0] mode, input int count, input bit garble);
      logic [APB_DATA_W-1:0] fill;
      fill = garble ? $urandom() : '0;
      write_csr(REG_INTERP_MODE, {fill[APB_DATA_W-1:MODE_W], mode});
      write_csr(REG_ENTRY_COUNT, {fill[APB_DATA_W-1:COUNT_W], count[COUNT_W-1:0]});
      settings_used = settings_used + 1;
   endtask

   // Stimulus: directed corners, a full table load, then random phases
   initial begin
      int unsigned roll, n_used, k, n_ops, count;
      logic [MODE_W-1:0] mode;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty table, then a small table with a plateau and a falling slope
      gap_ceiling = 0;
      queue_sample('0);
      queue_sample('1);
      queue_write(0, 1000, 32'd0);
      queue_write(1, 20000, 32'hFFFF_FFFF);
      queue_write(2, 20000, 32'd1000000);
      queue_write(3, CDF_ONE, 32'd7);
      settle_idle();

      // One entry: below the point, on it, and the search overrun
      set_config(MODE_LINEAR, 1, 1'b0);
      queue_sample(16'd0);
      queue_sample(16'd1000);
      queue_sample(16'd1001);
      queue_sample('1);
      settle_idle();

      // Four entries: rounding up, on a point, falling segment, below the first point
      set_config(MODE_CEIL, 4, 1'b0);
      queue_sample(16'd10000);
      queue_sample(16'd20000);
      queue_sample(16'd30000);
      queue_sample('1);
      queue_sample(16'd999);
      settle_idle();

      set_config(MODE_LINEAR, 4, 1'b0);
      queue_sample(16'd10000);
      queue_sample(16'd30000);
      settle_idle();

      set_config(MODE_SPARE, 4, 1'b0);
      queue_sample(16'd10000);
      queue_sample(16'd30000);
      settle_idle();

      set_config(MODE_DISCRETE, 4, 1'b0);
      queue_sample(16'd30000);
      settle_idle();

      // Fill every entry so any count is legal from here on
      load_table(TABLE_DEPTH, 1'b1);
      settle_idle();

      gap_ceiling = 7;
      set_config(MODE_CEIL, TABLE_DEPTH, 1'b0);
      repeat (30) queue_sample(pick_draw(TABLE_DEPTH));
      settle_idle();
      set_config(MODE_LINEAR, (1 << COUNT_W) - 1, 1'b1);
      repeat (15) queue_sample(pick_draw(TABLE_DEPTH));
      settle_idle();
      set_config(MODE_DISCRETE, TABLE_DEPTH + 1, 1'b0);
      repeat (10) queue_sample(pick_draw(TABLE_DEPTH));
      settle_idle();

      // Random phases: new setting, fresh table prefix, samples with stray writes
      while (items_queued < ITEM_BUDGET) begin
         gap_ceiling = ($urandom_range(3) == 0) ? 0 : 7;
         mode = MODE_W'($urandom_range(3));
         roll = $urandom_range(19);
         case (roll)
            0: count = 0;
            1: count = TABLE_DEPTH;
            2: count = $urandom_range((1 << COUNT_W) - 1, TABLE_DEPTH + 1);
            3, 4: count = $urandom_range(TABLE_DEPTH - 1, 17);
            default: count = $urandom_range(16, 1);
         endcase
         n_used = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
         set_config(mode, count, 1'($urandom_range(1)));
         k = (n_used > 24) ? $urandom_range(24, 1) : n_used;
         load_table(k, $urandom_range(4) != 0);
         n_ops = $urandom_range(40, 10);
         repeat (n_ops) begin
            if ($urandom_range(9) == 0)
               queue_write($urandom_range(TABLE_DEPTH - 1), $urandom_range(CDF_ONE), $urandom());
            else
               queue_sample(pick_draw(n_used));
         end
         settle_idle();
      end

      repeat (8) @(posedge clock);
      $display("tb: %0d entry writes and %0d samples over %0d register settings",
               writes_sent, samples_sent, settings_used);
      $display("tb: all four modes, counts 0 to 2047, ordered and scattered tables");
      if (fault_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d faults", fault_count);
         $display("tb: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("tb: timed out, %0d samples outstanding", expected_samples.size());
      $display("tb: done, errors");
      $finish;
   end

endmodule
